// File: hw/rtl/partial_extended_euclid_defines.svh
`ifndef PARTIAL_EXTENDED_EUCLID_DEFINES_SVH
`define PARTIAL_EXTENDED_EUCLID_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

  localparam int WORD_BITS = 64;
  localparam int REM_BITS  = WORD_BITS - 1;
  localparam int CNT_BITS  = $clog2(REM_BITS);

  localparam int FLD_REM_BITS = 63;
  localparam int FLD_COF_BITS = 64;
  localparam int IN_BITS      = 192;
  localparam int OUT_BITS     = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cur_gt_bound;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/pee_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "partial_extended_euclid_defines.svh"

module pee_ctrl
  import pee_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.cur_gt_bound) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_BITS'(REM_BITS - 1)) begin
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `PEE_ASSERT_IMP(a_cnt_range, state_r == ST_DIV, cnt_r <= CNT_BITS'(REM_BITS - 1), "count overrun")
  `PEE_ASSERT_NXT(a_div_to_upd, state_r == ST_DIV && cnt_r == CNT_BITS'(REM_BITS - 1), state_r == ST_UPDATE, "missed update")
  `PEE_ASSERT_NXT(a_done_valid, cmd.out_load, out_valid_r, "result not presented")
  `PEE_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready, "pending word overwritten")

endmodule

`default_nettype wire

// File: hw/rtl/pee_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "partial_extended_euclid_defines.svh"

module pee_dpath
  import pee_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  [FLD_REM_BITS-1:0] prev_remainder,
  input  wire  [FLD_REM_BITS-1:0] cur_remainder,
  input  wire  [FLD_REM_BITS-1:0] stop_bound,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [FLD_REM_BITS-1:0] out_prev_remainder,
  output logic [FLD_REM_BITS-1:0] out_cur_remainder,
  output logic [FLD_COF_BITS-1:0] out_prev_cofactor,
  output logic [FLD_COF_BITS-1:0] out_cur_cofactor
);

  logic [REM_BITS-1:0]     rprev_r, rcur_r, p_r, d_r;
  logic [FLD_REM_BITS-1:0] bound_r;
  logic [WORD_BITS-1:0]    cprev_r, ccur_r, acc_r;
  logic [FLD_REM_BITS-1:0] oprev_r, ocur_r;
  logic [FLD_COF_BITS-1:0] ocprev_r, occur_r;

  logic [REM_BITS:0]       trial;
  logic [REM_BITS:0]       diff;
  logic                    ge;

  assign trial = {p_r, d_r[REM_BITS-1]};
  assign diff  = trial - {1'b0, rcur_r};
  assign ge    = trial >= {1'b0, rcur_r};

  assign sts.cur_gt_bound = FLD_REM_BITS'(rcur_r) > bound_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rprev_r <= REM_BITS'(prev_remainder);
      rcur_r  <= REM_BITS'(cur_remainder);
      bound_r <= stop_bound;
      cprev_r <= '0;
      ccur_r  <= '1;
    end
    if (cmd.div_init) begin
      p_r   <= '0;
      d_r   <= rprev_r;
      acc_r <= '0;
    end
    if (cmd.div_step) begin
      p_r   <= ge ? REM_BITS'(diff) : REM_BITS'(trial);
      d_r   <= d_r << 1;
      acc_r <= (acc_r << 1) + (ge ? ccur_r : '0);
    end
    if (cmd.update) begin
      rprev_r <= rcur_r;
      rcur_r  <= p_r;
      cprev_r <= ccur_r;
      ccur_r  <= cprev_r - acc_r;
    end
    if (cmd.out_load) begin
      oprev_r  <= FLD_REM_BITS'(rprev_r);
      ocur_r   <= FLD_REM_BITS'(rcur_r);
      ocprev_r <= FLD_COF_BITS'($signed(cprev_r));
      occur_r  <= FLD_COF_BITS'($signed(ccur_r));
    end
  end

  assign out_prev_remainder = oprev_r;
  assign out_cur_remainder  = ocur_r;
  assign out_prev_cofactor  = ocprev_r;
  assign out_cur_cofactor   = occur_r;

  `PEE_ASSERT_IMP(a_divisor_nz, cmd.div_step, rcur_r != '0, "zero divisor")
  `PEE_ASSERT_IMP(a_part_rem, cmd.div_step, p_r < rcur_r, "partial remainder out of range")

endmodule

`default_nettype wire

// File: hw/rtl/partial_extended_euclid.sv
// Partial extended Euclid: runs quotient steps on a remainder pair while the
// current remainder exceeds a bound, tracking cofactors that start at 0 and -1.
// Input channel in_*: one word per problem; in_tdata holds prev_remainder,
// cur_remainder, stop_bound (63 bits each, lowest first), zero padded to 192.
// Result channel out_*: one word per problem; out_tdata holds
// out_prev_remainder, out_cur_remainder (63 bits each), out_prev_cofactor,
// out_cur_cofactor (64-bit two's complement), lowest first, padded to 256.
// The problem is worked in k quotient steps; each step is a bit-serial
// restoring division (one quotient bit per cycle over the 63-bit remainder)
// that also accumulates quotient times cofactor, followed by an update step.
// k is at most about 91 for 63-bit operands. One problem is worked at a time;
// in_tready rises once the result is parked in the output register.
// Reset (rst_n low, synchronous) drops any work in flight and any pending
// result. While the receiver stalls, the result word holds; a finished
// problem waits in its final check until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module partial_extended_euclid
  import pee_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // [62:0] prev_remainder, [125:63] cur_remainder, [188:126] stop_bound
  input  wire  [IN_BITS-1:0]  in_tdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // [62:0] out_prev_remainder, [125:63] out_cur_remainder,
  // [189:126] out_prev_cofactor, [253:190] out_cur_cofactor
  output logic [OUT_BITS-1:0] out_tdata
);

  cmd_t                    cmd;
  sts_t                    sts;
  logic [FLD_REM_BITS-1:0] o_prev, o_cur;
  logic [FLD_COF_BITS-1:0] o_cprev, o_ccur;

  pee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pee_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .prev_remainder     (in_tdata[FLD_REM_BITS-1:0]),
    .cur_remainder      (in_tdata[2*FLD_REM_BITS-1:FLD_REM_BITS]),
    .stop_bound         (in_tdata[3*FLD_REM_BITS-1:2*FLD_REM_BITS]),
    .cmd                (cmd),
    .sts                (sts),
    .out_prev_remainder (o_prev),
    .out_cur_remainder  (o_cur),
    .out_prev_cofactor  (o_cprev),
    .out_cur_cofactor   (o_ccur)
  );

  assign out_tdata = {(OUT_BITS - 2*FLD_REM_BITS - 2*FLD_COF_BITS)'(0),
                      o_ccur, o_cprev, o_cur, o_prev};

endmodule

`default_nettype wire
